// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the HSV adjust block.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m: forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/phsv_pkg.sv -----
// Package for the HSV adjust block: pixel and config types, widths, codes.
// No dependencies.
package phsv_pkg;

	localparam int CH_W       = 8;
	localparam int FRAC_W     = 12;
	localparam int UNIT_W     = FRAC_W + 1;   // 0..4096
	localparam int HUE_W      = FRAC_W + 3;   // sector 0..5 plus fraction
	localparam int SCALE_W    = 10;
	localparam int FLOOR_W    = 9;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 10;
	localparam int DIV_NUM_W  = CH_W + FRAC_W;
	localparam int DIV_QUO_W  = UNIT_W;
	localparam int SECT_W     = 3;

	localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << FRAC_W);

	typedef struct packed {
		logic [CH_W-1:0] in_alpha;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_alpha;
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
	} pix_out_t;

	typedef struct packed {
		logic [SCALE_W-1:0] sat_scale;
		logic [SCALE_W-1:0] val_scale;
		logic [FLOOR_W-1:0] sat_floor;
		logic [FLOOR_W-1:0] val_floor;
	} cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAT_SCALE = 8'd0,
		CFG_VAL_SCALE = 8'd1,
		CFG_SAT_FLOOR = 8'd2,
		CFG_VAL_FLOOR = 8'd3
	} cfg_idx_t;

	localparam logic [SECT_W-1:0] SECT_RED   = 3'd0;
	localparam logic [SECT_W-1:0] SECT_GREEN = 3'd2;
	localparam logic [SECT_W-1:0] SECT_BLUE  = 3'd4;
	localparam logic [SECT_W-1:0] SECT_WRAP  = 3'd6;

	// what rides along the hue divider
	typedef struct packed {
		logic [CH_W-1:0]   alpha;
		logic [UNIT_W-1:0] v;
		logic [SECT_W-1:0] base;
		logic              neg;
		logic              d_zero;
	} hue_side_t;

endpackage

// ----- rtl/core/phsv_front.sv -----
// Input stage: max/min of the channels, value, divider numerators.
// Depends on phsv_pkg.
module phsv_front import phsv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  pix_in_t              pixel,
	output logic                 vld_s1,
	output logic [DIV_NUM_W-1:0] sat_num_s1,
	output logic [CH_W-1:0]      mx_s1,
	output logic                 mx_zero_s1,
	output logic [DIV_NUM_W-1:0] hue_num_s1,
	output logic [CH_W-1:0]      d_s1,
	output hue_side_t            side_s1
);

	logic [CH_W-1:0]   r, g, b, mx, mn, d, p;
	logic [UNIT_W-1:0] y;
	logic [4:0]        q0;
	logic [8:0]        rm;
	logic [UNIT_W-1:0] v;
	logic [SECT_W-1:0] base;
	logic              neg;

	always_comb begin
		r = pixel.in_red;
		g = pixel.in_green;
		b = pixel.in_blue;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		// mx/255 rounded: mx*16 plus (mx*16 + 127) / 255 by shift and one fixup
		y = {1'b0, mx, 4'b0} + UNIT_W'(127);
		q0 = y[12:8];
		rm = {1'b0, y[7:0]} + {4'b0, q0};
		v = {1'b0, mx, 4'b0} + UNIT_W'(q0) + UNIT_W'(rm >= 9'd255);
		if (r == mx) begin
			base = SECT_RED;
			neg = g < b;
			p = neg ? b - g : g - b;
		end else if (g == mx) begin
			base = SECT_GREEN;
			neg = b < r;
			p = neg ? r - b : b - r;
		end else begin
			base = SECT_BLUE;
			neg = r < g;
			p = neg ? g - r : r - g;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		sat_num_s1     <= {d, {FRAC_W{1'b0}}} + DIV_NUM_W'(mx >> 1);
		mx_s1          <= mx;
		mx_zero_s1     <= (mx == '0);
		hue_num_s1     <= {p, {FRAC_W{1'b0}}};
		d_s1           <= d;
		side_s1.alpha  <= pixel.in_alpha;
		side_s1.v      <= v;
		side_s1.base   <= base;
		side_s1.neg    <= neg;
		side_s1.d_zero <= (d == '0);
	end

endmodule

// ----- rtl/core/phsv_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Quotient must fit in QUO_W bits. Depends on phsv_pkg for defaults.
module phsv_div import phsv_pkg::*; #(
	parameter int NUM_W  = DIV_NUM_W,
	parameter int DEN_W  = CH_W,
	parameter int QUO_W  = DIV_QUO_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_vld,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s  [1:QUO_W];
	logic [DEN_W-1:0]  rem_s  [1:QUO_W];
	logic [QUO_W-1:0]  nq_s   [1:QUO_W];
	logic [DEN_W-1:0]  den_s  [1:QUO_W];
	logic [SIDE_W-1:0] side_s [1:QUO_W];

	for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
		logic              prev_vld;
		logic [DEN_W-1:0]  prev_rem;
		logic [QUO_W-1:0]  prev_nq;
		logic [DEN_W-1:0]  prev_den;
		logic [SIDE_W-1:0] prev_side;
		logic [DEN_W:0]    r2;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 1) begin : g_first
			assign prev_vld  = in_vld;
			assign prev_rem  = DEN_W'(num[NUM_W-1:QUO_W]);
			assign prev_nq   = num[QUO_W-1:0];
			assign prev_den  = den;
			assign prev_side = side;
		end else begin : g_next
			assign prev_vld  = vld_s[k-1];
			assign prev_rem  = rem_s[k-1];
			assign prev_nq   = nq_s[k-1];
			assign prev_den  = den_s[k-1];
			assign prev_side = side_s[k-1];
		end

		// shift in the next numerator bit, subtract when it fits
		assign r2   = {prev_rem, prev_nq[QUO_W-1]};
		assign ge   = r2 >= {1'b0, prev_den};
		assign diff = r2 - {1'b0, prev_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
			nq_s[k]   <= {prev_nq[QUO_W-2:0], ge};
			den_s[k]  <= prev_den;
			side_s[k] <= prev_side;
		end
	end

	assign out_vld  = vld_s[QUO_W];
	assign quo      = nq_s[QUO_W];
	assign side_out = side_s[QUO_W];

endmodule

// ----- rtl/core/phsv_back.sv -----
// Back end: hue assembly, scale/floor/clamp, HSV to RGB, rounding.
// Four register stages. Depends on phsv_pkg.
module phsv_back import phsv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [DIV_QUO_W-1:0] s_quo,
	input  logic                 mx_zero,
	input  logic [DIV_QUO_W-1:0] h_quo,
	input  hue_side_t            side,
	input  cfg_t                 cfg,
	output logic                 done,
	output pix_out_t             result
);

	function automatic logic [UNIT_W-1:0] adjust(input logic [UNIT_W-1:0] x,
			input logic [SCALE_W-1:0] scale, input logic [FLOOR_W-1:0] flr);
		logic [UNIT_W+SCALE_W-1:0] prod;
		logic [UNIT_W+1:0]         yy;
		logic [UNIT_W+1:0]         lo;
		prod = x * scale + (UNIT_W+SCALE_W)'(128);
		yy = prod[UNIT_W+SCALE_W-1:8];
		lo = {2'b0, flr, 4'b0};
		if (yy < lo) yy = lo;
		if (yy > (UNIT_W+2)'(UNIT_ONE)) yy = (UNIT_W+2)'(UNIT_ONE);
		return yy[UNIT_W-1:0];
	endfunction

	function automatic logic [CH_W-1:0] to_channel(input logic [UNIT_W-1:0] c);
		logic [UNIT_W-1:0] cc;
		logic [20:0]       t;
		cc = (c > UNIT_ONE) ? UNIT_ONE : c;
		t = ({cc, 8'b0} - 21'(cc)) + 21'd2048;
		return t[19:12];
	endfunction

	// stage 15
	logic              vld_s15;
	logic [CH_W-1:0]   alpha_s15;
	logic [HUE_W-1:0]  h_s15;
	logic [UNIT_W-1:0] s_s15, v_s15;
	logic [HUE_W-1:0]  h_next;
	logic [SECT_W-1:0] top_sect;

	always_comb begin
		top_sect = (side.base == SECT_RED) ? SECT_WRAP : side.base;
		if (side.d_zero) begin
			h_next = '0;
		end else if (side.neg) begin
			h_next = {top_sect, {FRAC_W{1'b0}}} - HUE_W'(h_quo);
		end else begin
			h_next = {side.base, {FRAC_W{1'b0}}} + HUE_W'(h_quo);
		end
	end

	// stage 16
	logic              vld_s16;
	logic [CH_W-1:0]   alpha_s16;
	logic [UNIT_W-1:0] c_s16, v_s16, w_s16;
	logic [SECT_W-1:0] i_s16;
	logic [2*UNIT_W-1:0] vs_prod;
	logic [FRAC_W-1:0] f15;

	assign vs_prod = v_s15 * s_s15 + (2*UNIT_W)'(2048);
	assign f15     = h_s15[FRAC_W-1:0];

	// stage 17
	logic              vld_s17;
	logic [CH_W-1:0]   alpha_s17;
	logic [UNIT_W-1:0] c_s17, x_s17, m_s17;
	logic [SECT_W-1:0] i_s17;
	logic [2*UNIT_W-1:0] cw_prod;

	assign cw_prod = c_s16 * w_s16 + (2*UNIT_W)'(2048);

	// stage 18
	logic              vld_s18;
	pix_out_t          res_s18;
	logic [UNIT_W-1:0] rr, gg, bb;

	always_comb begin
		rr = '0;
		gg = '0;
		bb = '0;
		case (i_s17)
			3'd0: begin rr = c_s17; gg = x_s17; end
			3'd1: begin rr = x_s17; gg = c_s17; end
			3'd2: begin gg = c_s17; bb = x_s17; end
			3'd3: begin gg = x_s17; bb = c_s17; end
			3'd4: begin rr = x_s17; bb = c_s17; end
			default: begin rr = c_s17; bb = x_s17; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
			vld_s18 <= 1'b0;
		end else begin
			vld_s15 <= in_vld;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
			vld_s18 <= vld_s17;
		end
	end

	always_ff @(posedge clk) begin
		alpha_s15 <= side.alpha;
		h_s15     <= h_next;
		s_s15     <= adjust(mx_zero ? '0 : s_quo, cfg.sat_scale, cfg.sat_floor);
		v_s15     <= adjust(side.v, cfg.val_scale, cfg.val_floor);

		alpha_s16 <= alpha_s15;
		c_s16     <= vs_prod[FRAC_W+UNIT_W-1:FRAC_W];
		v_s16     <= v_s15;
		i_s16     <= h_s15[HUE_W-1:FRAC_W];
		w_s16     <= h_s15[FRAC_W] ? UNIT_ONE - UNIT_W'(f15) : UNIT_W'(f15);

		alpha_s17 <= alpha_s16;
		c_s17     <= c_s16;
		x_s17     <= cw_prod[FRAC_W+UNIT_W-1:FRAC_W];
		m_s17     <= v_s16 - c_s16;
		i_s17     <= i_s16;

		res_s18.out_alpha <= alpha_s17;
		res_s18.out_red   <= to_channel(rr + m_s17);
		res_s18.out_green <= to_channel(gg + m_s17);
		res_s18.out_blue  <= to_channel(bb + m_s17);
	end

	assign done   = vld_s18;
	assign result = res_s18;

endmodule

// ----- rtl/core/pixel_hsv_adjust.sv -----
// Pixel HSV saturation/value adjust, ARGB8888 in and out.
// done strobes once a taken start has passed through 1 input stage,
// 13 divider stages at one quotient bit each and 4 back-end stages.
// Throughput: one pixel per clock; busy stays low, results cannot be held.
// Reset clears the valid pipeline and loads the default scale and floor.
`include "assert_macros.svh"
module pixel_hsv_adjust import phsv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pix_in_t               pixel,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output pix_out_t              result
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sat_scale <= SCALE_W'(256);
			cfg_q.val_scale <= SCALE_W'(256);
			cfg_q.sat_floor <= '0;
			cfg_q.val_floor <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SAT_SCALE: cfg_q.sat_scale <= cfg_data;
				CFG_VAL_SCALE: cfg_q.val_scale <= cfg_data;
				CFG_SAT_FLOOR: cfg_q.sat_floor <= cfg_data[FLOOR_W-1:0];
				CFG_VAL_FLOOR: cfg_q.val_floor <= cfg_data[FLOOR_W-1:0];
				default: ;   // drop writes to unknown registers
			endcase
		end
	end

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic                 vld_s1, mx_zero_s1;
	logic [DIV_NUM_W-1:0] sat_num_s1, hue_num_s1;
	logic [CH_W-1:0]      mx_s1, d_s1;
	hue_side_t            side_s1;

	phsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (start && !busy),
		.pixel      (pixel),
		.vld_s1     (vld_s1),
		.sat_num_s1 (sat_num_s1),
		.mx_s1      (mx_s1),
		.mx_zero_s1 (mx_zero_s1),
		.hue_num_s1 (hue_num_s1),
		.d_s1       (d_s1),
		.side_s1    (side_s1)
	);

	logic                      sat_vld, hue_vld, sat_mx_zero;
	logic [DIV_QUO_W-1:0]      sat_quo, hue_quo;
	logic [$bits(hue_side_t)-1:0] hue_side_bits;
	hue_side_t                 hue_side;

	phsv_div #(
		.NUM_W  (DIV_NUM_W),
		.DEN_W  (CH_W),
		.QUO_W  (DIV_QUO_W),
		.SIDE_W (1)
	) u_sat_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.num      (sat_num_s1),
		.den      (mx_s1),
		.side     (mx_zero_s1),
		.out_vld  (sat_vld),
		.quo      (sat_quo),
		.side_out (sat_mx_zero)
	);

	phsv_div #(
		.NUM_W  (DIV_NUM_W),
		.DEN_W  (CH_W),
		.QUO_W  (DIV_QUO_W),
		.SIDE_W ($bits(hue_side_t))
	) u_hue_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.num      (hue_num_s1),
		.den      (d_s1),
		.side     (side_s1),
		.out_vld  (hue_vld),
		.quo      (hue_quo),
		.side_out (hue_side_bits)
	);

	assign hue_side = hue_side_t'(hue_side_bits);

	phsv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sat_vld),
		.s_quo   (sat_quo),
		.mx_zero (sat_mx_zero),
		.h_quo   (hue_quo),
		.side    (hue_side),
		.cfg     (cfg_q),
		.done    (done),
		.result  (result)
	);

	`ASSERT_PROP(a_div_lanes_aligned, clk, arst_n, sat_vld == hue_vld)
	`ASSERT_NEVER(a_black_not_gray, clk, arst_n, sat_vld && sat_mx_zero && !hue_side.d_zero)
	`ASSERT_PROP(a_back_latency, clk, arst_n, sat_vld |-> ##4 done)

endmodule
